// ----- sv/tlrs_pkg.sv -----
// ============================================================================
// tlrs_pkg: shared definitions for the reciprocal square root core
// Field widths, operation codes and the stage control record that the
// pipeline passes from the table read stage to the interpolation stage.
// ============================================================================
package tlrs_pkg;

    localparam int OPERAND_W     = 63;
    localparam int ENTRY_INDEX_W = 9;
    localparam int ENTRY_W       = 17;
    localparam int RESULT_W      = 33;
    localparam int MANT_W        = 32;
    localparam int MSB_W         = 6;
    localparam int SHIFT_W       = 6;
    localparam int AMT_W         = 5;

    localparam logic [MANT_W-1:0] MANT_BASE = 32'h4000_0000;
    localparam int                EXP_BIAS  = 31;

    typedef enum logic {
        OP_COMPUTE = 1'b0,
        OP_LOAD    = 1'b1
    } op_t;

    typedef struct packed {
        logic                      valid;
        logic                      zero;
        logic signed [SHIFT_W-1:0] shift;
    } ctl_t;

endpackage

// ----- sv/tlrs_ram.sv -----
// ============================================================================
// tlrs_ram: generic memory with one write port and two read ports
// Both read ports are registered and advance only when rd_en is high.
// ============================================================================
module tlrs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 385
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- sv/tlrs_norm.sv -----
// ============================================================================
// tlrs_norm: operand normalization
// Finds the leading one, picks an even shift that brings the mantissa into
// [2^30, 2^32) and returns the mantissa offset and the output shift.
// ============================================================================
module tlrs_norm (
    input  logic [tlrs_pkg::OPERAND_W-1:0]      operand,
    output logic [tlrs_pkg::MANT_W-1:0]         offset,
    output logic signed [tlrs_pkg::SHIFT_W-1:0] half_shift,
    output logic                                is_zero
);

    logic [tlrs_pkg::MSB_W-1:0]   msb;
    logic signed [tlrs_pkg::MSB_W:0] s_raw;
    logic signed [tlrs_pkg::MSB_W:0] s_even;
    logic [tlrs_pkg::MSB_W-1:0]   amt;
    logic [tlrs_pkg::OPERAND_W:0] wide;
    logic [tlrs_pkg::OPERAND_W:0] shifted;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < tlrs_pkg::OPERAND_W; i++)
        begin
            if (operand[i])
            begin
                msb = tlrs_pkg::MSB_W'(i);
            end
        end
        s_raw  = $signed({1'b0, msb}) - (tlrs_pkg::MSB_W+1)'(tlrs_pkg::EXP_BIAS);
        s_even = s_raw + $signed({{tlrs_pkg::MSB_W{1'b0}}, s_raw[0]});
        wide   = {1'b0, operand};
        if (s_even[tlrs_pkg::MSB_W])
        begin
            amt     = tlrs_pkg::MSB_W'(-s_even);
            shifted = wide << amt;
        end
        else
        begin
            amt     = s_even[tlrs_pkg::MSB_W-1:0];
            shifted = wide >> amt;
        end
        offset     = shifted[tlrs_pkg::MANT_W-1:0] - tlrs_pkg::MANT_BASE;
        half_shift = tlrs_pkg::SHIFT_W'(s_even >>> 1) - tlrs_pkg::SHIFT_W'(1);
        is_zero    = (operand == '0);
    end

endmodule

// ----- sv/tlrs_lerp.sv -----
// ============================================================================
// tlrs_lerp: linear interpolation and output scaling
// Registers the slope product of two neighboring table entries, then adds
// the floored step to the lower entry and applies the output shift.
// ============================================================================
module tlrs_lerp #(
    parameter int FRAC_BITS = 23
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  tlrs_pkg::ctl_t                     ctl_in,
    input  logic [tlrs_pkg::ENTRY_W-1:0]       lo,
    input  logic [tlrs_pkg::ENTRY_W-1:0]       hi,
    input  logic [FRAC_BITS-1:0]               frac,
    output tlrs_pkg::ctl_t                     ctl_out,
    output logic [tlrs_pkg::RESULT_W-1:0]      value
);

    localparam int DIFF_W = tlrs_pkg::ENTRY_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    tlrs_pkg::ctl_t                  ctl_reg;
    logic [tlrs_pkg::ENTRY_W-1:0]    lo_reg;
    logic signed [PROD_W-1:0]        prod_reg;

    logic signed [DIFF_W-1:0]        diff;
    logic signed [PROD_W-1:0]        prod;
    logic signed [PROD_W-1:0]        step;
    logic signed [PROD_W-1:0]        sum;
    logic [tlrs_pkg::RESULT_W-1:0]   interp;
    logic [tlrs_pkg::AMT_W-1:0]      amt;

    always_comb
    begin
        diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
        prod = PROD_W'(diff) * $signed({1'b0, frac});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg   <= lo;
            prod_reg <= prod;
        end
    end

    // The arithmetic shift floors the step, also for a falling slope.
    always_comb
    begin
        step   = prod_reg >>> FRAC_BITS;
        sum    = PROD_W'($signed({1'b0, lo_reg})) + step;
        interp = tlrs_pkg::RESULT_W'(sum[tlrs_pkg::ENTRY_W-1:0]);
        if (ctl_reg.shift < 0)
        begin
            amt   = tlrs_pkg::AMT_W'(-ctl_reg.shift);
            value = interp << amt;
        end
        else
        begin
            amt   = tlrs_pkg::AMT_W'(ctl_reg.shift);
            value = interp >> amt;
        end
        if (ctl_reg.zero)
        begin
            value = '1;
        end
    end

    assign ctl_out = ctl_reg;

endmodule

// ----- sv/table_lerp_reciprocal_sqrt_core.sv -----
// ============================================================================
// table_lerp_reciprocal_sqrt_core: table interpolated 1/sqrt(x)
// Usage:
//   An input beat on item_valid/item_ready carries op, operand, entry_index
//   and entry_value. A load beat writes entry_value into the table at
//   entry_index and gives no result; an index at or past TABLE_ENTRIES is
//   dropped. A compute beat takes the Q.32 operand and later gives one
//   Q.16 result beat on result_valid/result_ready.
//   The table must be loaded before any compute beat reads the entries that
//   its operand selects; its contents are undefined after reset.
//   One beat is taken every cycle while the result receiver keeps up; the
//   four-stage pipeline (input register, table read, slope product, result
//   register) reads both table entries together through the two read ports.
//   Reset clears every stage valid flag and leaves the table alone.
//   When the receiver stalls, the result register holds and earlier stages
//   keep filling until each holds a beat; item_ready drops only then.
//   A zero operand gives the saturated result of all ones.
// ============================================================================
module table_lerp_reciprocal_sqrt_core #(
    parameter int TABLE_ENTRIES = 385,
    parameter int FRAC_BITS     = 23
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                op,
    input  logic [tlrs_pkg::OPERAND_W-1:0]      operand,
    input  logic [tlrs_pkg::ENTRY_INDEX_W-1:0]  entry_index,
    input  logic [tlrs_pkg::ENTRY_W-1:0]        entry_value,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [tlrs_pkg::RESULT_W-1:0]       result
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int IX_W   = tlrs_pkg::MANT_W - FRAC_BITS;
    localparam int SEL_W  = ((IX_W > ADDR_W) ? IX_W : ADDR_W) + 1;
    localparam int LD_W   = ((tlrs_pkg::ENTRY_INDEX_W > ADDR_W) ?
                             tlrs_pkg::ENTRY_INDEX_W : ADDR_W) + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    logic                                s1_op_reg;
    logic [tlrs_pkg::OPERAND_W-1:0]      s1_operand_reg;
    logic [tlrs_pkg::ENTRY_INDEX_W-1:0]  s1_index_reg;
    logic [tlrs_pkg::ENTRY_W-1:0]        s1_value_reg;

    tlrs_pkg::ctl_t                      s2_ctl_reg;
    tlrs_pkg::ctl_t                      s2_ctl_next;
    logic [FRAC_BITS-1:0]                s2_frac_reg;

    logic                                result_valid_reg;
    logic                                result_valid_next;
    logic [tlrs_pkg::RESULT_W-1:0]       result_reg;

    logic                                res_en;
    logic                                s3_en;
    logic                                s2_en;
    logic                                s1_en;

    logic [tlrs_pkg::MANT_W-1:0]         offset;
    logic signed [tlrs_pkg::SHIFT_W-1:0] half_shift;
    logic                                is_zero;
    logic [IX_W-1:0]                     ix;
    logic [SEL_W-1:0]                    ix_ext;
    logic                                clamp;
    logic [ADDR_W-1:0]                   lo_addr;
    logic [ADDR_W-1:0]                   hi_addr;
    logic [FRAC_BITS-1:0]                frac_sel;
    logic [LD_W-1:0]                     ld_ext;
    logic                                ld_in_range;
    logic                                s1_compute;
    logic                                wr_en;

    logic [tlrs_pkg::ENTRY_W-1:0]        lo_data;
    logic [tlrs_pkg::ENTRY_W-1:0]        hi_data;
    tlrs_pkg::ctl_t                      lerp_ctl;
    logic [tlrs_pkg::RESULT_W-1:0]       lerp_value;

    // Each stage moves when the stage after it is empty or moving.
    assign res_en     = !result_valid_reg || result_ready;
    assign s3_en      = !lerp_ctl.valid || res_en;
    assign s2_en      = !s2_ctl_reg.valid || s3_en;
    assign s1_en      = !s1_valid_reg || s2_en;
    assign item_ready = s1_en;

    assign s1_valid_next = s1_en ? item_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_op_reg      <= op;
            s1_operand_reg <= operand;
            s1_index_reg   <= entry_index;
            s1_value_reg   <= entry_value;
        end
    end

    tlrs_norm u_norm (
        .operand    (s1_operand_reg),
        .offset     (offset),
        .half_shift (half_shift),
        .is_zero    (is_zero)
    );

    always_comb
    begin
        ix       = offset[tlrs_pkg::MANT_W-1:FRAC_BITS];
        ix_ext   = SEL_W'(ix);
        clamp    = 32'(ix) >= 32'(TABLE_ENTRIES - 1);
        lo_addr  = clamp ? LAST_ADDR : ix_ext[ADDR_W-1:0];
        hi_addr  = clamp ? LAST_ADDR : ix_ext[ADDR_W-1:0] + ADDR_W'(1);
        frac_sel = clamp ? '0 : offset[FRAC_BITS-1:0];
    end

    assign s1_compute  = s1_valid_reg && (s1_op_reg == tlrs_pkg::OP_COMPUTE);
    assign ld_ext      = LD_W'(s1_index_reg);
    assign ld_in_range = 32'(ld_ext) < 32'(TABLE_ENTRIES);
    assign wr_en       = s1_valid_reg && (s1_op_reg == tlrs_pkg::OP_LOAD)
                         && ld_in_range && s2_en;

    tlrs_ram #(
        .WIDTH (tlrs_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (ld_ext[ADDR_W-1:0]),
        .wr_data   (s1_value_reg),
        .rd_en     (s2_en),
        .rd_addr_a (lo_addr),
        .rd_addr_b (hi_addr),
        .rd_data_a (lo_data),
        .rd_data_b (hi_data)
    );

    always_comb
    begin
        s2_ctl_next = s2_ctl_reg;
        if (s2_en)
        begin
            s2_ctl_next.valid = s1_compute;
            s2_ctl_next.zero  = is_zero;
            s2_ctl_next.shift = half_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else
        begin
            s2_ctl_reg <= s2_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_frac_reg <= frac_sel;
        end
    end

    tlrs_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (s3_en),
        .ctl_in  (s2_ctl_reg),
        .lo      (lo_data),
        .hi      (hi_data),
        .frac    (s2_frac_reg),
        .ctl_out (lerp_ctl),
        .value   (lerp_value)
    );

    assign result_valid_next = res_en ? lerp_ctl.valid : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_en && lerp_ctl.valid)
        begin
            result_reg <= lerp_value;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_load_gives_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_op_reg == tlrs_pkg::OP_LOAD) && s2_en |=> !s2_ctl_reg.valid)
        else $error("A load beat entered the result path.");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |=> result_valid_reg && $stable(result_reg))
        else $error("A stalled result changed or vanished.");

    a_zero_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        lerp_ctl.valid && lerp_ctl.zero && res_en |=> result_reg == '1)
        else $error("A zero operand did not give the saturated result.");

    a_neighbor_read: assert property (@(posedge clk) disable iff (!rst_n)
        s1_compute && !is_zero |->
            (hi_addr == ADDR_W'(lo_addr + ADDR_W'(1))) ||
            ((hi_addr == LAST_ADDR) && (lo_addr == LAST_ADDR)))
        else $error("The table read addresses are not neighbors.");

endmodule
